FILE: design/bounded_retransmit_spool_assert.svh
// assertion macros for the retransmit spool
`ifndef BOUNDED_RETRANSMIT_SPOOL_ASSERT_SVH
`define BOUNDED_RETRANSMIT_SPOOL_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define BRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spool assertion failed");
// next-cycle implication, disabled during reset
`define BRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spool assertion failed");
`else
`define BRS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/brs_pkg.sv
`default_nettype none
package brs_pkg;

  localparam int STORE_DEPTH_DEF = 512;
  localparam int SIZE_BITS_DEF   = 16;

  localparam logic [8:0]  RESET_MAX_MSG   = 9'd256;
  localparam logic [31:0] RESET_MAX_BYTES = 32'd1048576;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_ACK    = 2'd1,
    OP_ROTATE = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic {
    REG_MAX_MSG   = 1'b0,
    REG_MAX_BYTES = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_ACK,
    ST_EMIT
  } state_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic shift;   // take the right neighbor's entry
    logic load;    // cell at the load index takes the load entry
    logic renum;   // sequence becomes position plus one
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: design/brs_cell.sv
`default_nettype none
module brs_cell #(
  parameter int IDX       = 0,
  parameter int IDX_W     = 9,
  parameter int SIZE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire brs_pkg::cell_ctrl_t   ctrl,
  input  wire logic [IDX_W-1:0]      load_idx,
  input  wire logic [31:0]           load_seq,
  input  wire logic [SIZE_BITS-1:0]  load_size,
  input  wire logic                  load_crit,
  input  wire logic [31:0]           nbr_seq,
  input  wire logic [SIZE_BITS-1:0]  nbr_size,
  input  wire logic                  nbr_crit,
  output logic      [31:0]           seq_o,
  output logic      [SIZE_BITS-1:0]  size_o,
  output logic                       crit_o
);
  import brs_pkg::*;

  logic [31:0]          seq_r;
  logic [SIZE_BITS-1:0] size_r;
  logic                 crit_r;

  always_ff @(posedge clk) begin
    priority if (ctrl.load && (load_idx == IDX_W'(IDX))) begin
      seq_r  <= load_seq;
      size_r <= load_size;
      crit_r <= load_crit;
    end else if (ctrl.shift) begin
      seq_r  <= nbr_seq;
      size_r <= nbr_size;
      crit_r <= nbr_crit;
    end else if (ctrl.renum) begin
      seq_r <= 32'(IDX + 1);
    end
  end

  assign seq_o  = seq_r;
  assign size_o = size_r;
  assign crit_o = crit_r;

endmodule
`default_nettype wire

FILE: design/bounded_retransmit_spool.sv
`default_nettype none
// Retransmit spool: keeps unacknowledged messages in order in a chain of
// entry cells, oldest in cell 0, bounded by a message count and a byte total.
// One item enters, one result comes out. An append rotates the whole spool
// through cell 0 once, one entry per cycle, dropping the oldest non-critical
// entries while over the limits (and down to nine tenths once anything went),
// then admits or rejects. An acknowledge pops one entry from the head per
// cycle. The length of an append is set by the single compare point at the
// head of the cell chain. A new item is taken once the previous one has gone
// into the output register, even while that result is stalled.
`include "bounded_retransmit_spool_assert.svh"
module bounded_retransmit_spool #(
  parameter int STORE_DEPTH = brs_pkg::STORE_DEPTH_DEF,
  parameter int SIZE_BITS   = brs_pkg::SIZE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [15:0] in_record_bytes,
  input  wire logic        in_is_critical,
  input  wire logic [31:0] in_ack_sequence,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_assigned_sequence,
  output logic             out_rejected,
  output logic             out_rotated,
  output logic             out_gap_flag,
  output logic [9:0]       out_entry_count,
  output logic [32:0]      out_held_bytes,
  output logic [31:0]      out_drop_total
);
  import brs_pkg::*;

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int OCC_W = $clog2(STORE_DEPTH + 1);
  // count compares: room for ten times the occupancy and nine times the limit
  localparam int CMP_W = ((OCC_W > 9) ? OCC_W : 9) + 4;
  localparam int BYT_W = 37;

  // config registers
  logic [8:0]  max_msg_r;
  logic [31:0] max_bytes_r;

  // spool state
  state_t               state_r, state_nxt;
  logic [OCC_W-1:0]     occ_r, occ_nxt;
  logic [OCC_W-1:0]     nc_r, nc_nxt;       // non-critical entries held
  logic [OCC_W-1:0]     left_r, left_nxt;   // entries still to pass the head
  logic [32:0]          bytes_r, bytes_nxt;
  logic [31:0]          next_seq_r, next_seq_nxt;
  logic [31:0]          acked_r, acked_nxt;
  logic                 gap_r, gap_nxt;
  logic [31:0]          drop_r, drop_nxt;
  logic                 dropped_r, dropped_nxt;

  // latched item
  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic                 crit_r, crit_nxt;

  // per-item result flags
  logic [31:0]          assigned_r, assigned_nxt;
  logic                 rejected_r, rejected_nxt;
  logic                 rotated_r, rotated_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;

  // cell chain wiring
  logic [31:0]          seq_q  [STORE_DEPTH];
  logic [SIZE_BITS-1:0] sz_q   [STORE_DEPTH];
  logic                 crit_q [STORE_DEPTH];
  cell_ctrl_t           ctrl;
  logic [IDX_W-1:0]     ld_idx;
  logic [31:0]          ld_seq;
  logic [SIZE_BITS-1:0] ld_size;
  logic                 ld_crit;

  logic                 in_xfer;
  logic [31:0]          ack_last;

  // limit compares
  logic [CMP_W-1:0] occ_c, msg_c;
  logic [BYT_W-1:0] byt_c, lim_c, bsum_c;
  logic             over1, over2, above9, store_full;

  genvar gi;
  generate
    for (gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
      if (gi == STORE_DEPTH - 1) begin : g_last
        // nothing to the right of the tail cell
        brs_cell #(.IDX(gi), .IDX_W(IDX_W), .SIZE_BITS(SIZE_BITS)) u_cell (
          .clk      (clk),
          .ctrl     (ctrl),
          .load_idx (ld_idx),
          .load_seq (ld_seq),
          .load_size(ld_size),
          .load_crit(ld_crit),
          .nbr_seq  (32'd0),
          .nbr_size ({SIZE_BITS{1'b0}}),
          .nbr_crit (1'b0),
          .seq_o    (seq_q[gi]),
          .size_o   (sz_q[gi]),
          .crit_o   (crit_q[gi])
        );
      end else begin : g_mid
        brs_cell #(.IDX(gi), .IDX_W(IDX_W), .SIZE_BITS(SIZE_BITS)) u_cell (
          .clk      (clk),
          .ctrl     (ctrl),
          .load_idx (ld_idx),
          .load_seq (ld_seq),
          .load_size(ld_size),
          .load_crit(ld_crit),
          .nbr_seq  (seq_q[gi+1]),
          .nbr_size (sz_q[gi+1]),
          .nbr_crit (crit_q[gi+1]),
          .seq_o    (seq_q[gi]),
          .size_o   (sz_q[gi]),
          .crit_o   (crit_q[gi])
        );
      end
    end
  endgenerate

  // config register writes, only while idle, a rule that the user keeps; the block itself has no check for it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_msg_r   <= RESET_MAX_MSG;
      max_bytes_r <= RESET_MAX_BYTES;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_MSG:   max_msg_r   <= cfg_wdata[8:0];
        REG_MAX_BYTES: max_bytes_r <= cfg_wdata;
      endcase
    end
  end

  // exact forms of the 1x, 2x and 9/10 limit tests
  always_comb begin
    occ_c      = CMP_W'(occ_r);
    msg_c      = CMP_W'(max_msg_r);
    byt_c      = BYT_W'(bytes_r);
    lim_c      = BYT_W'(max_bytes_r);
    bsum_c     = byt_c + BYT_W'(size_r);
    over1      = ((occ_c + CMP_W'(1)) > msg_c) || (bsum_c > lim_c);
    over2      = ((occ_c + CMP_W'(1)) > (msg_c << 1)) || (bsum_c > (lim_c << 1));
    above9     = (((occ_c << 3) + (occ_c << 1)) > ((msg_c << 3) + msg_c)) ||
                 (((byt_c << 3) + (byt_c << 1)) > ((lim_c << 3) + lim_c));
    store_full = (occ_r == OCC_W'(STORE_DEPTH));
  end

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign ack_last = next_seq_r - 32'd1;
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      nc_r        <= '0;
      left_r      <= '0;
      bytes_r     <= '0;
      next_seq_r  <= 32'd1;
      acked_r     <= '0;
      gap_r       <= 1'b0;
      drop_r      <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      nc_r        <= nc_nxt;
      left_r      <= left_nxt;
      bytes_r     <= bytes_nxt;
      next_seq_r  <= next_seq_nxt;
      acked_r     <= acked_nxt;
      gap_r       <= gap_nxt;
      drop_r      <= drop_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item latches and result flags, payload only
  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    crit_r     <= crit_nxt;
    assigned_r <= assigned_nxt;
    rejected_r <= rejected_nxt;
    rotated_r  <= rotated_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_assigned_sequence <= assigned_r;
      out_rejected          <= rejected_r;
      out_rotated           <= rotated_r;
      out_gap_flag          <= gap_r;
      out_entry_count       <= 10'(occ_r);
      out_held_bytes        <= bytes_r;
      out_drop_total        <= drop_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    nc_nxt        = nc_r;
    left_nxt      = left_r;
    bytes_nxt     = bytes_r;
    next_seq_nxt  = next_seq_r;
    acked_nxt     = acked_r;
    gap_nxt       = gap_r;
    drop_nxt      = drop_r;
    dropped_nxt   = dropped_r;
    size_nxt      = size_r;
    crit_nxt      = crit_r;
    assigned_nxt  = assigned_r;
    rejected_nxt  = rejected_r;
    rotated_nxt   = rotated_r;
    out_valid_nxt = out_valid_r;
    ctrl          = '0;
    ld_idx        = IDX_W'(occ_r - OCC_W'(1));  // tail of the spool
    ld_seq        = seq_q[0];
    ld_size       = sz_q[0];
    ld_crit       = crit_q[0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          size_nxt     = SIZE_BITS'(in_record_bytes);
          crit_nxt     = in_is_critical;
          assigned_nxt = '0;
          rejected_nxt = 1'b0;
          rotated_nxt  = 1'b0;
          dropped_nxt  = 1'b0;
          state_nxt    = ST_EMIT;
          unique case (opcode_t'(in_opcode))
            OP_APPEND: begin
              left_nxt  = occ_r;
              state_nxt = ST_SCAN;
            end
            OP_ACK: begin
              if (in_ack_sequence > acked_r) begin
                acked_nxt = (in_ack_sequence < ack_last) ? in_ack_sequence : ack_last;
                state_nxt = ST_ACK;
              end
            end
            OP_ROTATE: begin
              // with a gap flagged, renumber every cell in place from 1
              if (gap_r) begin
                ctrl.renum   = 1'b1;
                next_seq_nxt = 32'(occ_r) + 32'd1;
                acked_nxt    = '0;
                gap_nxt      = 1'b0;
                rotated_nxt  = 1'b1;
              end
            end
            OP_NONE: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // every entry passes cell 0 once; kept ones go back in at the tail
        if (left_r == '0) begin
          state_nxt = ST_DECIDE;
        end else begin
          left_nxt   = left_r - OCC_W'(1);
          ctrl.shift = 1'b1;
          if (!crit_q[0] && (over1 || (dropped_r && above9))) begin
            occ_nxt     = occ_r - OCC_W'(1);
            nc_nxt      = nc_r - OCC_W'(1);
            bytes_nxt   = bytes_r - 33'(sz_q[0]);
            drop_nxt    = (drop_r == '1) ? drop_r : drop_r + 32'd1;
            gap_nxt     = 1'b1;
            dropped_nxt = 1'b1;
          end else begin
            ctrl.load = 1'b1;
          end
        end
      end

      ST_DECIDE: begin
        if ((over1 && (!crit_r || over2)) || store_full) begin
          drop_nxt     = (drop_r == '1) ? drop_r : drop_r + 32'd1;
          gap_nxt      = 1'b1;
          rejected_nxt = 1'b1;
        end else begin
          ctrl.load    = 1'b1;
          ld_idx       = IDX_W'(occ_r);
          ld_seq       = next_seq_r;
          ld_size      = size_r;
          ld_crit      = crit_r;
          assigned_nxt = next_seq_r;
          next_seq_nxt = next_seq_r + 32'd1;
          occ_nxt      = occ_r + OCC_W'(1);
          bytes_nxt    = bytes_r + 33'(size_r);
          if (!crit_r) begin
            nc_nxt = nc_r + OCC_W'(1);
          end
        end
        state_nxt = ST_EMIT;
      end

      ST_ACK: begin
        // pop acknowledged entries off the head, one per cycle
        if ((occ_r != '0) && (seq_q[0] <= acked_r)) begin
          ctrl.shift = 1'b1;
          occ_nxt    = occ_r - OCC_W'(1);
          bytes_nxt  = bytes_r - 33'(sz_q[0]);
          if (!crit_q[0]) begin
            nc_nxt = nc_r - OCC_W'(1);
          end
        end else begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // checks on the spool bookkeeping
  `BRS_ASSERT_NOW(a_occ_bound, clk, rst_n, 1'b1, occ_r <= OCC_W'(STORE_DEPTH))
  `BRS_ASSERT_NOW(a_nc_bound, clk, rst_n, 1'b1, nc_r <= occ_r)
  `BRS_ASSERT_NOW(a_scan_left, clk, rst_n, 1'b1, left_r <= occ_r)
  `BRS_ASSERT_NOW(a_reject_noseq, clk, rst_n, out_valid_r && out_rejected,
                  out_assigned_sequence == 32'd0)

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import brs_pkg::*;

  localparam int DEPTH = STORE_DEPTH_DEF;
  localparam longint unsigned MASK33 = 64'h1_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_OFF_LEN = 400;

  // one result transfer as the block reports it
  typedef struct {
    logic [31:0] seq;
    logic        rej;
    logic        rot;
    logic        gap;
    logic [9:0]  cnt;
    logic [32:0] bytes;
    logic [31:0] drops;
  } spool_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [15:0] in_record_bytes;
  logic        in_is_critical;
  logic [31:0] in_ack_sequence;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_assigned_sequence;
  logic        out_rejected;
  logic        out_rotated;
  logic        out_gap_flag;
  logic [9:0]  out_entry_count;
  logic [32:0] out_held_bytes;
  logic [31:0] out_drop_total;

  bounded_retransmit_spool u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_record_bytes(in_record_bytes), .in_is_critical(in_is_critical),
    .in_ack_sequence(in_ack_sequence),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_assigned_sequence(out_assigned_sequence), .out_rejected(out_rejected),
    .out_rotated(out_rotated), .out_gap_flag(out_gap_flag),
    .out_entry_count(out_entry_count), .out_held_bytes(out_held_bytes),
    .out_drop_total(out_drop_total)
  );

  // shadow copy of the spool: entries oldest first plus the counters
  logic [31:0]     sh_seq  [DEPTH];
  logic [15:0]     sh_size [DEPTH];
  bit              sh_crit [DEPTH];
  int unsigned     sh_occ;
  longint unsigned sh_held;
  logic [31:0]     sh_next;
  logic [31:0]     sh_acked;
  bit              sh_gap;
  logic [31:0]     sh_drops;
  longint unsigned lim_msgs;
  longint unsigned lim_bytes;

  // predictions in transfer order: the sender fills, the checker empties
  spool_result_t exp_ring [16];
  int unsigned sent_count = 0;
  int unsigned seen_count = 0;
  int  mismatches = 0;
  int  unmatched = 0;
  int  cycles = 0;

  // idling controls
  bit  quiet_tx;
  bit  quiet_rx;
  int  hold_off_reqs = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // spool predictor
  // ---------------------------------------------------------------------------
  function automatic void spool_clear();
    sh_occ = 0; sh_held = 0; sh_next = 32'd1; sh_acked = '0;
    sh_gap = 0; sh_drops = '0;
    lim_msgs = 64'(RESET_MAX_MSG);
    lim_bytes = 64'(RESET_MAX_BYTES);
  endfunction

  function automatic void count_loss();
    if (sh_drops != 32'hFFFF_FFFF) sh_drops = sh_drops + 32'd1;
    sh_gap = 1;
  endfunction

  function automatic void remove_entry(int unsigned pos);
    sh_held = (sh_held - 64'(sh_size[pos])) & MASK33;
    for (int unsigned i = pos; i + 1 < sh_occ; i++) begin
      sh_seq[i]  = sh_seq[i+1];
      sh_size[i] = sh_size[i+1];
      sh_crit[i] = sh_crit[i+1];
    end
    sh_occ--;
  endfunction

  // drops the oldest entry that is allowed to go, if any
  function automatic bit drop_compactable();
    for (int unsigned i = 0; i < sh_occ; i++) begin
      if (!sh_crit[i]) begin
        remove_entry(i);
        count_loss();
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic bit over_limit(longint unsigned add, longint unsigned factor);
    return (64'(sh_occ) + 64'd1 > lim_msgs * factor) || (sh_held + add > lim_bytes * factor);
  endfunction

  function automatic bit above_ninety_pct();
    return (64'(sh_occ) * 64'd10 > lim_msgs * 64'd9) ||
           (sh_held * 64'd10 > lim_bytes * 64'd9);
  endfunction

  function automatic spool_result_t spool_step(opcode_t op, logic [15:0] size,
                                                bit crit, logic [31:0] ack);
    spool_result_t r;
    bit dropped;
    logic [31:0] last;
    r.seq = '0; r.rej = 0; r.rot = 0;
    case (op)
      OP_APPEND: begin
        dropped = 0;
        while (over_limit(64'(size), 64'd1) && drop_compactable()) dropped = 1;
        if (dropped)
          while (above_ninety_pct() && drop_compactable()) ;
        if ((over_limit(64'(size), 64'd1) && (!crit || over_limit(64'(size), 64'd2))) ||
            sh_occ >= DEPTH) begin
          count_loss();
          r.rej = 1;
        end else begin
          r.seq = sh_next;
          sh_seq[sh_occ]  = sh_next;
          sh_size[sh_occ] = size;
          sh_crit[sh_occ] = crit;
          sh_occ++;
          sh_next = sh_next + 32'd1;
          sh_held = (sh_held + 64'(size)) & MASK33;
        end
      end
      OP_ACK: begin
        if (ack > sh_acked) begin
          last = sh_next - 32'd1;
          sh_acked = (ack < last) ? ack : last;
          while (sh_occ > 0 && sh_seq[0] <= sh_acked) remove_entry(0);
        end
      end
      OP_ROTATE: begin
        if (sh_gap) begin
          for (int unsigned i = 0; i < sh_occ; i++) sh_seq[i] = i + 1;
          sh_next = sh_occ + 1;
          sh_acked = '0;
          sh_gap = 0;
          r.rot = 1;
        end
      end
      default: ;  // unused opcode only reports the state
    endcase
    r.gap = sh_gap;
    r.cnt = sh_occ[9:0];
    r.bytes = sh_held[32:0];
    r.drops = sh_drops;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (quiet_tx || roll < 50) return 0;
    if (roll < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  // offers one item, holds it until the transfer, predicts it, then idles if gap is above zero
  task automatic send_item(opcode_t op, logic [15:0] size, bit crit,
                           logic [31:0] ack, int gap);
    @(negedge clk);
    in_valid = 1'b1;
    in_opcode = op;
    in_record_bytes = size;
    in_is_critical = crit;
    in_ack_sequence = ack;
    do @(posedge clk); while (in_stall);
    exp_ring[sent_count[3:0]] = spool_step(op, size, crit, ack);
    sent_count++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // waits until every result is back, then lets the block settle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (seen_count == sent_count);
    repeat (8) @(posedge clk);
  endtask

  // registers change only while the block is idle
  task automatic write_limits(logic [8:0] msgs, logic [31:0] bytes);
    drain();
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = REG_MAX_MSG; cfg_wdata = {23'd0, msgs};
    @(negedge clk);
    cfg_index = REG_MAX_BYTES; cfg_wdata = bytes;
    @(negedge clk);
    cfg_we = 1'b0;
    lim_msgs = 64'(msgs);
    lim_bytes = 64'(bytes);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stall with short and long stretches, plus hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    int run_left;
    int roll;
    int hold_left;
    int reqs_seen;
    stall_left = 0;
    run_left = 0;
    hold_left = 0;
    reqs_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_reqs != reqs_seen) begin
        reqs_seen = hold_off_reqs;
        hold_left = HOLD_OFF_LEN;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (quiet_rx) begin
        out_stall = 1'b0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (run_left > 0) begin
        out_stall = 1'b0;
        run_left--;
      end else begin
        roll = int'($urandom_range(0, 99));
        if (roll < 45) stall_left = int'($urandom_range(1, 3));
        else if (roll < 50) stall_left = int'($urandom_range(15, 50));
        run_left = int'($urandom_range(0, 8));
        out_stall = 1'b0;
      end
    end
  end

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h", name, exp_v, act_v);
    end
  endtask

  // each result transfer is checked against the oldest prediction
  always @(posedge clk) begin
    spool_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (seen_count == sent_count) begin
        unmatched++;
        mismatches++;
        if (mismatches <= 10) $display("mismatch: result transfer with none expected");
      end else begin
        exp_r = exp_ring[seen_count[3:0]];
        seen_count++;
        compare_field("assigned_sequence", 64'(exp_r.seq), 64'(out_assigned_sequence));
        compare_field("rejected", 64'(exp_r.rej), 64'(out_rejected));
        compare_field("rotated", 64'(exp_r.rot), 64'(out_rotated));
        compare_field("gap_flag", 64'(exp_r.gap), 64'(out_gap_flag));
        compare_field("entry_count", 64'(exp_r.cnt), 64'(out_entry_count));
        compare_field("held_bytes", 64'(exp_r.bytes), 64'(out_held_bytes));
        compare_field("drop_total", 64'(exp_r.drops), 64'(out_drop_total));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, every opcode and the corner cases, at reset limits first
  task automatic test_directed();
    send_item(OP_APPEND, 16'd1, 0, 32'd0, pick_gap());
    send_item(OP_APPEND, 16'hFFFF, 1, 32'hFFFF_FFFF, pick_gap());
    send_item(OP_NONE, 16'hFFFF, 1, 32'hFFFF_FFFF, pick_gap());
    send_item(OP_ROTATE, 16'd1, 0, 32'd0, pick_gap());        // rotate with no gap
    send_item(OP_ACK, 16'd1, 0, 32'd0, pick_gap());           // ack not above acked
    send_item(OP_ACK, 16'd7, 0, 32'hFFFF_FFFF, pick_gap());   // clamped to last sequence
    write_limits(9'd2, 32'd100);
    send_item(OP_APPEND, 16'd60, 0, 32'd0, pick_gap());
    send_item(OP_APPEND, 16'd60, 0, 32'd0, pick_gap());       // byte overflow drops oldest
    send_item(OP_APPEND, 16'd150, 1, 32'd0, pick_gap());      // critical up to twice
    send_item(OP_APPEND, 16'd90, 0, 32'd0, pick_gap());       // non-critical rejected
    send_item(OP_APPEND, 16'd250, 1, 32'd0, pick_gap());      // critical past twice
    send_item(OP_ROTATE, 16'd1, 0, 32'd0, pick_gap());        // renumber from 1
    send_item(OP_ACK, 16'd1, 0, 32'd1, pick_gap());
    write_limits(9'd0, 32'd0);                                // zero limits
    send_item(OP_APPEND, 16'd5, 0, 32'd0, pick_gap());
    send_item(OP_APPEND, 16'd5, 1, 32'd0, pick_gap());
    write_limits(9'd3, 32'd1);
    send_item(OP_APPEND, 16'd1, 0, 32'd0, pick_gap());
    send_item(OP_APPEND, 16'd2, 1, 32'd0, pick_gap());
    send_item(OP_APPEND, 16'd1, 1, 32'd0, pick_gap());
    write_limits(9'd256, 32'hFFFF_FFFF);
    send_item(OP_APPEND, 16'hFFFF, 0, 32'd0, pick_gap());
    send_item(OP_ACK, 16'd1, 0, 32'hFFFF_FFFF, pick_gap());
  endtask

  // mostly well-formed traffic with random content under one limit setting
  task automatic test_random_traffic(int n, logic [8:0] msgs, logic [31:0] bytes);
    int roll;
    int unsigned size_cap;
    logic [31:0] ack;
    logic [15:0] size;
    write_limits(msgs, bytes);
    size_cap = (bytes < 65535) ? ((bytes == 0) ? 1 : bytes) : 65535;
    for (int k = 0; k < n; k++) begin
      roll = int'($urandom_range(0, 99));
      size = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                          : 16'($urandom_range(1, size_cap));
      if (roll < 62) begin
        send_item(OP_APPEND, size, $urandom_range(0, 3) == 0, $urandom, pick_gap());
      end else if (roll < 84) begin
        if ($urandom_range(0, 9) == 0) ack = $urandom;
        else ack = sh_acked + $urandom_range(0, sh_next - sh_acked);
        send_item(OP_ACK, size, 1'($urandom_range(0, 1)), ack, pick_gap());
      end else if (roll < 96) begin
        send_item(OP_ROTATE, size, 1'($urandom_range(0, 1)), $urandom, pick_gap());
      end else begin
        send_item(OP_NONE, size, 1'($urandom_range(0, 1)), $urandom, pick_gap());
      end
    end
  endtask

  // critical appends fill the whole store, then one more finds it full
  task automatic test_store_full();
    write_limits(9'd256, 32'hFFFF_FFFF);
    quiet_tx = 1;
    quiet_rx = 1;
    for (int k = 0; k <= DEPTH; k++) send_item(OP_APPEND, 16'd1, 1, 32'd0, 0);
    send_item(OP_APPEND, 16'd3, 0, 32'd0, 0);
    send_item(OP_ROTATE, 16'd1, 0, 32'd0, 0);
    send_item(OP_ACK, 16'd1, 0, 32'hFFFF_FFFF, 0);
    quiet_tx = 0;
    quiet_rx = 0;
  endtask

  // receiver holds off long enough that the block backs up onto its input
  task automatic test_back_pressure();
    write_limits(9'd8, 32'd5000);
    hold_off_reqs++;
    for (int k = 0; k < 30; k++)
      send_item(k % 3 == 2 ? OP_ACK : OP_APPEND, 16'($urandom_range(1, 1500)),
                1'($urandom_range(0, 1)), sh_next - 32'd2, 0);
    drain();  // sender waits for every result before going on
    send_item(OP_ROTATE, 16'd1, 0, 32'd0, 0);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_MAX_MSG; cfg_wdata = '0;
    in_valid = 1'b0; in_opcode = OP_NONE; in_record_bytes = 16'd1;
    in_is_critical = 1'b0; in_ack_sequence = '0;
    quiet_tx = 0; quiet_rx = 0;
    spool_clear();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_traffic(250, 9'd4, 32'd40000);
    test_random_traffic(120, 9'd1, 32'd65535);
    test_random_traffic(250, 9'd16, 32'd200000);
    test_back_pressure();
    test_random_traffic(200, 9'd8, 32'd1000);
    quiet_tx = 1; quiet_rx = 1;                 // stretch with no idling at all
    test_random_traffic(150, 9'd12, 32'd300000);
    quiet_tx = 0; quiet_rx = 0;
    test_random_traffic(100, 9'd3, 32'd1);
    test_random_traffic(120, 9'd256, 32'hFFFF_FFFF);
    test_store_full();
    test_random_traffic(150, 9'd5, 32'd12000);

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && seen_count == sent_count) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
